FILE: rtl/core/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, types and codes for the multitap feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

  localparam int CHANNELS    = 2;
  localparam int LINE_FRAMES = 4096;
  localparam int FF_TAPS     = 3;
  localparam int FB_TAPS     = 3;

  localparam int SampleW = 24;
  localparam int GainW   = 16;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int TapCnt  = 6;
  localparam int TapIdxW = 3;
  localparam int TapHalf = 3;

  localparam int ChW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FrameW    = $clog2(LINE_FRAMES);
  localparam int LineWords = LINE_FRAMES * CHANNELS;
  localparam int AddrW     = $clog2(LineWords);

  // seven 40-bit products summed, plus headroom
  localparam int AccW   = 43;
  localparam int ProdW  = AccW + GainW;
  localparam int RndSh  = 26;
  localparam int ResW   = ProdW + 1 - RndSh;

  localparam int SampleMax = 8388607;
  localparam int SampleMin = -8388608;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DRY_GAIN = 3'd0,
    REG_OUT_GAIN = 3'd1,
    REG_FF_TAP_A = 3'd2,
    REG_FF_TAP_B = 3'd3,
    REG_FF_TAP_C = 3'd4,
    REG_FB_TAP_A = 3'd5,
    REG_FB_TAP_B = 3'd6,
    REG_FB_TAP_C = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    MAC_IDLE  = 2'd0,
    MAC_LOAD  = 2'd1,
    MAC_ADD   = 2'd2,
    MAC_SCALE = 2'd3
  } mac_op_e;

  typedef struct packed {
    mac_op_e                   op;
    logic signed [SampleW-1:0] sample;
    logic signed [GainW-1:0]   gain;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      clip;
  } mac_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/mfd_line_ram.sv
// ----------------------------------------------------------------------------
// mfd_line_ram
// Single-write, single-read delay line memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_line_ram (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [mfd_pkg::AddrW-1:0]        waddr_i,
  input  wire logic signed [mfd_pkg::SampleW-1:0] wdata_i,
  input  wire logic [mfd_pkg::AddrW-1:0]        raddr_i,
  output logic signed [mfd_pkg::SampleW-1:0]    rdata_o
);

  logic signed [mfd_pkg::SampleW-1:0] mem_q [mfd_pkg::LineWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfd_mac.sv
// ----------------------------------------------------------------------------
// mfd_mac
// Shared multiply-accumulate unit: tap sums, output gain, rounding, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mfd_pkg::mac_ctrl_t ctrl_i,
  output mfd_pkg::mac_res_t       res_o
);

  localparam int AccW  = mfd_pkg::AccW;
  localparam int ProdW = mfd_pkg::ProdW;
  localparam int ResW  = mfd_pkg::ResW;
  localparam int SW    = mfd_pkg::SampleW;

  localparam logic signed [ProdW:0]  RndBias = (ProdW+1)'(1) << (mfd_pkg::RndSh - 1);
  localparam logic signed [ResW-1:0] ResMax  = ResW'(mfd_pkg::SampleMax);
  localparam logic signed [ResW-1:0] ResMin  = ResW'(mfd_pkg::SampleMin);

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] scale_q, scale_d;
  logic signed [AccW-1:0]  mult_a;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW:0]   rnd;
  logic signed [ResW-1:0]  res_wide;

  assign mult_a = (ctrl_i.op == mfd_pkg::MAC_SCALE) ? acc_q
                : {{(AccW-SW){ctrl_i.sample[SW-1]}}, ctrl_i.sample};
  assign prod   = mult_a * ctrl_i.gain;

  always_comb begin
    acc_d   = acc_q;
    scale_d = scale_q;
    unique case (ctrl_i.op)
      mfd_pkg::MAC_LOAD:  acc_d   = $signed(prod[AccW-1:0]);
      mfd_pkg::MAC_ADD:   acc_d   = acc_q + $signed(prod[AccW-1:0]);
      mfd_pkg::MAC_SCALE: scale_d = prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      scale_q <= '0;
    end else begin
      acc_q   <= acc_d;
      scale_q <= scale_d;
    end
  end

  // round half up at bit 26, then clamp to Q1.23
  assign rnd      = {scale_q[ProdW-1], scale_q} + RndBias;
  assign res_wide = $signed(rnd[ProdW:mfd_pkg::RndSh]);

  always_comb begin
    res_o.clip = 1'b1;
    if (res_wide > ResMax) begin
      res_o.sample = SW'(mfd_pkg::SampleMax);
    end else if (res_wide < ResMin) begin
      res_o.sample = SW'(mfd_pkg::SampleMin);
    end else begin
      res_o.sample = res_wide[SW-1:0];
      res_o.clip   = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/multitap_feedback_delay.sv
// ----------------------------------------------------------------------------
// multitap_feedback_delay
// Multitap feedforward / feedback comb delay on interleaved Q1.23 audio.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one sample request, channels
// interleaved in order. Output channel: out_valid_o / out_ready_i carry the
// processed sample, its channel index and a clip flag, one per input.
// Config: cfg_we_i writes register cfg_idx_i with cfg_wdata_i;
// write only while no sample is in flight.
// Sequence: for each sample the shared multiplier runs dry gain, six taps
// (one delay line read each), and the output gain in turn, then a
// round/clamp step. The input line is written on accept; the output
// line in the ST_FIN state.
// Reset: gains 1.0, taps 0, both lines read as zero until first written
// (tracked by write position and a wrap flag, no clearing pass).
// Stall: the result sits in an output register, so the next sample is
// taken while it waits; the sequencer holds in its last state only when a
// second result is ready and the first has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_feedback_delay (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mfd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [mfd_pkg::CfgW-1:0]            cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mfd_pkg::SampleW-1:0]  in_sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [mfd_pkg::SampleW-1:0]       out_sample_o,
  output logic                                     out_channel_o,
  output logic                                     clipped_o
);

  localparam int SW     = mfd_pkg::SampleW;
  localparam int GW     = mfd_pkg::GainW;
  localparam int AddrW  = mfd_pkg::AddrW;
  localparam int FrameW = mfd_pkg::FrameW;
  localparam int ChW    = mfd_pkg::ChW;
  localparam int TW     = mfd_pkg::TapIdxW;

  localparam logic [ChW-1:0]    ChLast    = ChW'(mfd_pkg::CHANNELS - 1);
  localparam logic [FrameW-1:0] FrameLast = FrameW'(mfd_pkg::LINE_FRAMES - 1);
  localparam logic [AddrW-1:0]  ChMul     = AddrW'(mfd_pkg::CHANNELS);
  localparam logic [TW-1:0]     TapLast   = TW'(mfd_pkg::TapCnt - 1);
  localparam logic [TW-1:0]     TapHalf   = TW'(mfd_pkg::TapHalf);
  localparam logic [TW-1:0]     FfTaps    = TW'(mfd_pkg::FF_TAPS);
  localparam logic [TW-1:0]     FbTaps    = TW'(mfd_pkg::FB_TAPS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TAP   = 5'b00010,
    ST_LAST  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [GW-1:0] dry_q, outg_q;
  logic [mfd_pkg::CfgW-1:0] tap_cfg_q [mfd_pkg::TapCnt];

  logic [TW-1:0]     tap_q, tap_d;
  logic [FrameW-1:0] fp_q, fp_d;
  logic [ChW-1:0]    ch_q, ch_d;
  logic              wrap_q, wrap_d;

  logic                 rd_fb_q, rd_ok_q;
  logic signed [GW-1:0] rd_gain_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_sample_q;
  logic                 out_channel_q, clipped_q;

  logic [AddrW-1:0]     here;
  logic [mfd_pkg::CfgW-1:0] tap_word;
  logic [FrameW-1:0]    tap_frame;
  logic [AddrW-1:0]     tap_addr;
  logic                 tap_fb, tap_en, tap_ok;
  logic signed [SW-1:0] in_rdata, out_rdata, rd_sample;
  logic                 in_fire, out_free, fin_go;

  mfd_pkg::mac_ctrl_t mac_ctrl;
  mfd_pkg::mac_res_t  mac_res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q  <= GW'(8192);
      outg_q <= GW'(8192);
      for (int i = 0; i < mfd_pkg::TapCnt; i++) begin
        tap_cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (mfd_pkg::reg_e'(cfg_idx_i))
        mfd_pkg::REG_DRY_GAIN: dry_q        <= cfg_wdata_i[GW-1:0];
        mfd_pkg::REG_OUT_GAIN: outg_q       <= cfg_wdata_i[GW-1:0];
        mfd_pkg::REG_FF_TAP_A: tap_cfg_q[0] <= cfg_wdata_i;
        mfd_pkg::REG_FF_TAP_B: tap_cfg_q[1] <= cfg_wdata_i;
        mfd_pkg::REG_FF_TAP_C: tap_cfg_q[2] <= cfg_wdata_i;
        mfd_pkg::REG_FB_TAP_A: tap_cfg_q[3] <= cfg_wdata_i;
        mfd_pkg::REG_FB_TAP_B: tap_cfg_q[4] <= cfg_wdata_i;
        mfd_pkg::REG_FB_TAP_C: tap_cfg_q[5] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // addressing
  assign here      = AddrW'(fp_q) * ChMul + AddrW'(ch_q);
  assign tap_word  = tap_cfg_q[tap_q];
  assign tap_frame = fp_q - tap_word[16 +: FrameW];
  assign tap_addr  = AddrW'(tap_frame) * ChMul + AddrW'(ch_q);
  assign tap_fb    = (tap_q >= TapHalf);
  assign tap_en    = tap_fb ? ((tap_q - TapHalf) < FbTaps) : (tap_q < FfTaps);
  // input entry at the write position is already written this item
  assign tap_ok    = wrap_q || (tap_fb ? (tap_addr < here) : (tap_addr <= here));

  always_ff @(posedge clk_i) begin
    rd_fb_q   <= tap_fb;
    rd_ok_q   <= tap_ok;
    rd_gain_q <= tap_en ? tap_word[GW-1:0] : '0;
  end

  assign rd_sample = !rd_ok_q ? '0 : (rd_fb_q ? out_rdata : in_rdata);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_go     = (state_q == ST_FIN) && out_free;

  mfd_line_ram u_in_line (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (here),
    .wdata_i (in_sample_i),
    .raddr_i (tap_addr),
    .rdata_o (in_rdata)
  );

  mfd_line_ram u_out_line (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_FIN),
    .waddr_i (here),
    .wdata_i (mac_res.sample),
    .raddr_i (tap_addr),
    .rdata_o (out_rdata)
  );

  mfd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .res_o  (mac_res)
  );

  // sequencer
  always_comb begin
    state_d         = state_q;
    tap_d           = tap_q;
    fp_d            = fp_q;
    ch_d            = ch_q;
    wrap_d          = wrap_q;
    mac_ctrl.op     = mfd_pkg::MAC_IDLE;
    mac_ctrl.sample = rd_sample;
    mac_ctrl.gain   = rd_gain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mac_ctrl.op     = mfd_pkg::MAC_LOAD;
          mac_ctrl.sample = in_sample_i;
          mac_ctrl.gain   = dry_q;
          tap_d           = '0;
          state_d         = ST_TAP;
        end
      end
      ST_TAP: begin
        if (tap_q != '0) begin
          mac_ctrl.op = mfd_pkg::MAC_ADD;
        end
        if (tap_q == TapLast) begin
          state_d = ST_LAST;
        end else begin
          tap_d = tap_q + TW'(1);
        end
      end
      ST_LAST: begin
        mac_ctrl.op = mfd_pkg::MAC_ADD;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        mac_ctrl.op   = mfd_pkg::MAC_SCALE;
        mac_ctrl.gain = outg_q;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (ch_q == ChLast) begin
            ch_d = '0;
            fp_d = fp_q + FrameW'(1);
            if (fp_q == FrameLast) begin
              wrap_d = 1'b1;
            end
          end else begin
            ch_d = ch_q + ChW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      fp_q    <= '0;
      ch_q    <= '0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      fp_q    <= fp_d;
      ch_q    <= ch_d;
      wrap_q  <= wrap_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_sample_q  <= mac_res.sample;
      out_channel_q <= ch_q[0];
      clipped_q     <= mac_res.clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_channel_o = out_channel_q;
  assign clipped_o     = clipped_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAP) |-> (tap_q <= TapLast))
    else $error("tap counter out of range");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_sample_o == SW'(mfd_pkg::SampleMax) || out_sample_o == SW'(mfd_pkg::SampleMin)))
    else $error("clip flag without saturated sample");

endmodule

`default_nettype wire

FILE: sim/mfd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfd_checker
// Watches the register port and both request channels of the delay block,
// keeps its own copy of the delay lines and taps, predicts each processed
// sample and compares it with what the block hands out, in order.
// ----------------------------------------------------------------------------

module mfd_checker
  import mfd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [SampleW-1:0] out_sample_i,
  input  logic                      out_channel_i,
  input  logic                      clipped_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      channel;
    logic                      clip;
  } wet_sample_t;

  logic signed [SampleW-1:0] dry_line [LineWords];
  logic signed [SampleW-1:0] wet_line [LineWords];
  logic [FrameW-1:0]         frame_pos;
  int                        chan;
  logic signed [GainW-1:0]   dry_gain;
  logic signed [GainW-1:0]   out_gain;
  logic [CfgW-1:0]           ff_tap [3];
  logic [CfgW-1:0]           fb_tap [3];
  wet_sample_t               due_samples [$];
  wet_sample_t               head;
  int                        fails;
  int                        reports;

  assign fail_count_o = fails;

  function automatic int tap_addr(logic [CfgW-1:0] tap);
    logic [FrameW-1:0] f;
    f = frame_pos - tap[16 +: FrameW];
    return int'(f) * CHANNELS + chan;
  endfunction

  function automatic longint tap_term(logic [CfgW-1:0] tap, logic signed [SampleW-1:0] s);
    return longint'($signed(tap[GainW-1:0])) * longint'(s);
  endfunction

  function automatic wet_sample_t filter_sample(logic signed [SampleW-1:0] x);
    int          here;
    longint      acc;
    longint      y;
    wet_sample_t r;
    here = int'(frame_pos) * CHANNELS + chan;
    dry_line[here] = x;
    acc = longint'(dry_gain) * longint'(x);
    for (int i = 0; i < FF_TAPS; i++) acc += tap_term(ff_tap[i], dry_line[tap_addr(ff_tap[i])]);
    // feedback reads the line before this result lands in it
    for (int i = 0; i < FB_TAPS; i++) acc += tap_term(fb_tap[i], wet_line[tap_addr(fb_tap[i])]);
    y = (acc * longint'(out_gain) + (longint'(1) <<< (RndSh - 1))) >>> RndSh;
    r.clip = 1'b1;
    if (y > SampleMax) begin
      r.sample = SampleW'(SampleMax);
    end else if (y < SampleMin) begin
      r.sample = SampleW'(SampleMin);
    end else begin
      r.sample = SampleW'(y);
      r.clip   = 1'b0;
    end
    r.channel = chan[0];
    wet_line[here] = r.sample;
    chan++;
    if (chan >= CHANNELS) begin
      chan = 0;
      frame_pos++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < LineWords; a++) begin
        dry_line[a] = '0;
        wet_line[a] = '0;
      end
      frame_pos = '0;
      chan      = 0;
      dry_gain  = 16'sd8192;
      out_gain  = 16'sd8192;
      for (int i = 0; i < 3; i++) begin
        ff_tap[i] = '0;
        fb_tap[i] = '0;
      end
      due_samples.delete();
      fails     = 0;
      reports   = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DRY_GAIN: dry_gain  = cfg_wdata_i[GainW-1:0];
          REG_OUT_GAIN: out_gain  = cfg_wdata_i[GainW-1:0];
          REG_FF_TAP_A: ff_tap[0] = cfg_wdata_i;
          REG_FF_TAP_B: ff_tap[1] = cfg_wdata_i;
          REG_FF_TAP_C: ff_tap[2] = cfg_wdata_i;
          REG_FB_TAP_A: fb_tap[0] = cfg_wdata_i;
          REG_FB_TAP_B: fb_tap[1] = cfg_wdata_i;
          REG_FB_TAP_C: fb_tap[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) due_samples.push_back(filter_sample(in_sample_i));
      if (out_valid_i && out_ready_i) begin
        if (due_samples.size() == 0) begin
          fails++;
          if (reports < 10) $display("%0t: result %0d with no request pending", $time, out_sample_i);
          reports++;
        end else begin
          head = due_samples.pop_front();
          if (out_sample_i !== head.sample || out_channel_i !== head.channel ||
              clipped_i !== head.clip) begin
            fails++;
            if (reports < 10)
              $display("%0t: mismatch sample %0d/%0d channel %0d/%0d clip %0d/%0d (exp/act)",
                       $time, head.sample, out_sample_i, head.channel, out_channel_i,
                       head.clip, clipped_i);
            reports++;
          end
        end
      end
      pending_o <= due_samples.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multitap feedback delay: a directed pass over sample and
// gain extremes and tap delay corner cases, then randomly configured phases
// of random audio with random gaps on both channels. The checker predicts
// and compares; this module reports the verdict.
// ----------------------------------------------------------------------------

module tb;
  import mfd_pkg::*;

  localparam int RandPhases = 8;
  localparam int PhaseItems = 210;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_idx;
  logic [CfgW-1:0]           cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SampleW-1:0] in_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SampleW-1:0] out_sample;
  logic                      out_channel;
  logic                      clipped;
  int                        fail_count;
  int                        pending;
  int                        sent;
  int                        settings;
  logic [CfgW-1:0]           regs [8];
  logic signed [SampleW-1:0] edge_samples [8];

  always #10ns clk = ~clk;

  multitap_feedback_delay uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_sample_i  (in_sample),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_sample_o (out_sample),
    .out_channel_o(out_channel),
    .clipped_o    (clipped)
  );

  mfd_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_sample_i  (in_sample),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_sample_i (out_sample),
    .out_channel_i(out_channel),
    .clipped_i    (clipped),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [CfgW-1:0] tap_word(int delay, int gain);
    return {delay[15:0], gain[15:0]};
  endfunction

  function automatic int rand_gain(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    if (r == 2) return 0;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r <= 5) return $urandom_range(1, 12);
    if (r <= 7) return $urandom_range(13, 200);
    // aliases past the end of the line
    if (r == 8) return LINE_FRAMES * $urandom_range(1, 15) + $urandom_range(0, 3);
    return $urandom_range(0, 65535);
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       v = SampleMax;
        1:       v = SampleMin;
        2:       v = 0;
        default: v = -1;
      endcase
    end else if (r <= 3) begin
      v = int'($urandom_range(0, 8191)) - 4096;
    end else begin
      v = $urandom();
    end
    return v[SampleW-1:0];
  endfunction

  task automatic load_settings(input logic [CfgW-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] v);
    in_valid  <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait for every result, then let the pipe settle
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_set(input logic signed [SampleW-1:0] s [8], input int n);
    for (int i = 0; i < n; i++) send_sample(s[i]);
    drain(12);
  endtask

  initial begin
    #50ms;
    $display("multitap_feedback_delay test failed");
    $finish;
  end

  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) n = 150;
      else n = $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int  gap;
    logic burst;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    sent      = 0;
    settings  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains, no taps
    edge_samples = '{SampleW'(SampleMax), SampleW'(SampleMin), '0, -24'sd1, 24'sd1,
                     24'h555555, 24'hAAAAAA, 24'sd12345};
    send_set(edge_samples, 8);

    // maximum gains: zero-delay taps on both lines, aliased and muted taps
    regs[REG_DRY_GAIN] = CfgW'(32767);
    regs[REG_OUT_GAIN] = CfgW'(32767);
    regs[REG_FF_TAP_A] = tap_word(0, 32767);
    regs[REG_FF_TAP_B] = tap_word(1, 8192);
    regs[REG_FF_TAP_C] = tap_word(LINE_FRAMES + 1, -32768);
    regs[REG_FB_TAP_A] = tap_word(0, 8192);
    regs[REG_FB_TAP_B] = tap_word(1, 32767);
    regs[REG_FB_TAP_C] = tap_word(65535, 0);
    load_settings(regs);
    edge_samples = '{SampleW'(SampleMax), SampleW'(SampleMax), SampleW'(SampleMin),
                     SampleW'(SampleMin), SampleW'(SampleMax), SampleW'(SampleMin), '0,
                     24'sd12345};
    send_set(edge_samples, 8);

    // most negative gains
    regs[REG_DRY_GAIN] = CfgW'(-32768);
    regs[REG_OUT_GAIN] = CfgW'(-32768);
    regs[REG_FF_TAP_A] = tap_word(2, -32768);
    regs[REG_FF_TAP_B] = tap_word(0, 0);
    regs[REG_FF_TAP_C] = tap_word(3, 1);
    regs[REG_FB_TAP_A] = tap_word(1, -32768);
    regs[REG_FB_TAP_B] = tap_word(2, 4096);
    regs[REG_FB_TAP_C] = tap_word(0, -1);
    load_settings(regs);
    edge_samples = '{SampleW'(SampleMin), SampleW'(SampleMax), SampleW'(SampleMin),
                     SampleW'(SampleMax), 24'sd1, -24'sd1, SampleW'(SampleMax),
                     SampleW'(SampleMin)};
    send_set(edge_samples, 7);

    for (int p = 0; p < RandPhases; p++) begin
      regs[REG_DRY_GAIN] = CfgW'(rand_gain(16384));
      regs[REG_OUT_GAIN] = CfgW'(rand_gain(16384));
      regs[REG_FF_TAP_A] = tap_word(rand_delay(), rand_gain(8192));
      regs[REG_FF_TAP_B] = tap_word(rand_delay(), rand_gain(8192));
      regs[REG_FF_TAP_C] = tap_word(rand_delay(), rand_gain(8192));
      regs[REG_FB_TAP_A] = tap_word(rand_delay(), rand_gain(4096));
      regs[REG_FB_TAP_B] = tap_word(rand_delay(), rand_gain(4096));
      regs[REG_FB_TAP_C] = tap_word(rand_delay(), rand_gain(4096));
      load_settings(regs);
      burst = (p % 3 == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n > 0) begin
          if (n == PhaseItems / 2 || $urandom_range(0, 149) == 0) begin
            drain(0);
          end else begin
            gap = burst ? 0 : idle_len();
            if (gap > 0) begin
              in_valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
        end
        send_sample(rand_sample());
      end
      drain(12);
    end

    drain(20);
    $display("%0d samples sent over %0d register settings, gains and tap delays at extremes",
             sent, settings);
    if (fail_count == 0 && pending == 0) begin
      $display("multitap_feedback_delay test passed");
    end else begin
      $display("multitap_feedback_delay test failed");
    end
    $finish;
  end

endmodule
